>>> sv/icdg_pkg.sv
// Shared types and constants for the central difference gradient block.
package icdg_pkg;

    localparam int ROW_W      = 12;
    localparam int COL_OUT_W  = 11;
    localparam int WREG_W     = 12;
    localparam int HREG_W     = 13;
    localparam int MAX_HEIGHT = 4096;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [WREG_W-1:0] WIDTH_RESET  = 12'd1920;
    localparam logic [HREG_W-1:0] HEIGHT_RESET = 13'd1080;

    // Register index, taken from paddr[2].
    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } icdg_reg_t;

    // Bit positions of the results one input pixel can cause, in emit order.
    localparam int RES_ABOVE  = 0;
    localparam int RES_BEHIND = 1;
    localparam int RES_CORNER = 2;
    localparam int RES_N      = 3;

    // Position flags of an accepted pixel.
    typedef struct packed {
        logic has_above;
        logic row_is_one;
        logic last_row;
        logic last_col;
        logic first_col;
        logic col_is_one;
    } icdg_flags_t;

endpackage

>>> sv/icdg_row_buf.sv
// Two row memories: the current row is written while the previous row is read ahead.
module icdg_row_buf #(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 16
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic                          sel,
    input  logic [$clog2(MAX_WIDTH)-1:0]  col,
    input  logic [$clog2(MAX_WIDTH)-1:0]  col_p1,
    input  logic [PIXEL_BITS-1:0]         pix,
    output logic [PIXEL_BITS-1:0]         cur_rd,
    output logic [PIXEL_BITS-1:0]         prev_rd
);
    import icdg_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    logic [PIXEL_BITS-1:0] mem_a [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] mem_b [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] rd_a_reg;
    logic [PIXEL_BITS-1:0] rd_b_reg;
    logic                  sel_reg;
    logic [ADDR_W-1:0]     addr_a;
    logic [ADDR_W-1:0]     addr_b;

    // The store being written is read at the same column (old contents, two rows up);
    // the other store is read one column ahead.
    assign addr_a = sel ? col_p1 : col;
    assign addr_b = sel ? col : col_p1;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            if (!sel) begin
                mem_a[col] <= pix;
            end
            rd_a_reg <= mem_a[addr_a];
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            if (sel) begin
                mem_b[col] <= pix;
            end
            rd_b_reg <= mem_b[addr_b];
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            sel_reg <= sel;
        end
    end

    assign cur_rd  = sel_reg ? rd_b_reg : rd_a_reg;
    assign prev_rd = sel_reg ? rd_a_reg : rd_b_reg;

endmodule

>>> sv/icdg_grad.sv
// Gradient stage: holds one pixel with its memory reads, emits up to three results.
module icdg_grad #(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rstn,
    input  logic                              load,
    input  logic [PIXEL_BITS-1:0]             ld_pix,
    input  logic [icdg_pkg::ROW_W-1:0]        ld_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]      ld_col,
    input  icdg_pkg::icdg_flags_t             ld_flags,
    input  logic [PIXEL_BITS-1:0]             cur_rd,
    input  logic [PIXEL_BITS-1:0]             prev_rd,
    output logic                              ready,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [PIXEL_BITS+1:0]      out_horiz,
    output logic signed [PIXEL_BITS+1:0]      out_vert,
    output logic [icdg_pkg::ROW_W-1:0]        out_row,
    output logic [icdg_pkg::COL_OUT_W-1:0]    out_col,
    output logic                              out_last
);
    import icdg_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int GRAD_W = PIXEL_BITS + 2;

    function automatic logic signed [GRAD_W-1:0] sub_pix(input logic [PIXEL_BITS-1:0] a,
                                                         input logic [PIXEL_BITS-1:0] b);
        return $signed({2'b00, a}) - $signed({2'b00, b});
    endfunction

    function automatic logic signed [GRAD_W-1:0] sub_dbl(input logic [PIXEL_BITS-1:0] a,
                                                         input logic [PIXEL_BITS-1:0] b);
        logic signed [GRAD_W-1:0] d;
        d = sub_pix(a, b);
        return d <<< 1;
    endfunction

    // Held pixel
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic [PIXEL_BITS-1:0]    s1_pix_reg;
    logic [ROW_W-1:0]         s1_row_reg;
    logic [COL_W-1:0]         s1_col_reg;
    icdg_flags_t              s1_flags_reg;
    logic [RES_N-1:0]         done_reg;
    logic [RES_N-1:0]         done_next;

    // Sliding window over the previous row and the current row.
    logic [PIXEL_BITS-1:0]    prev_c_reg;
    logic [PIXEL_BITS-1:0]    prev_cm1_reg;
    logic [PIXEL_BITS-1:0]    first_prev_reg;
    logic [PIXEL_BITS-1:0]    pix_d1_reg;
    logic [PIXEL_BITS-1:0]    pix_d2_reg;
    logic [PIXEL_BITS-1:0]    prev_c_eff;

    // Output register
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic signed [GRAD_W-1:0] m_horiz_reg;
    logic signed [GRAD_W-1:0] m_vert_reg;
    logic [ROW_W-1:0]         m_row_reg;
    logic [COL_OUT_W-1:0]     m_col_reg;
    logic                     m_last_reg;

    logic [RES_N-1:0]         present;
    logic [RES_N-1:0]         pend;
    logic [RES_N-1:0]         pick;
    logic                     out_free;
    logic                     emit;
    logic                     only_one;
    logic                     complete;

    logic signed [GRAD_W-1:0] h_above, v_above, h_behind, v_behind, h_corner, v_corner;
    logic signed [GRAD_W-1:0] sel_h, sel_v;
    logic [ROW_W-1:0]         sel_row;
    logic [COL_W-1:0]         sel_col;
    logic [COL_W+COL_OUT_W-1:0] col_wide;

    assign present[RES_ABOVE]  = s1_flags_reg.has_above;
    assign present[RES_BEHIND] = s1_flags_reg.last_row && !s1_flags_reg.first_col;
    assign present[RES_CORNER] = s1_flags_reg.last_row && s1_flags_reg.last_col;
    assign pend     = present & ~done_reg;
    assign out_free = !m_valid_reg || out_ready;
    assign emit     = s1_valid_reg && (pend != '0) && out_free;
    assign only_one = (pend & (pend - RES_N'(1))) == '0;
    assign complete = s1_valid_reg && ((pend == '0) || (emit && only_one));
    assign ready    = !s1_valid_reg || complete;

    assign prev_c_eff = s1_flags_reg.first_col ? first_prev_reg : prev_c_reg;

    always_comb begin
        // Pixel one row up, same column.
        if (s1_flags_reg.first_col) begin
            h_above = sub_dbl(prev_rd, prev_c_eff);
        end else if (s1_flags_reg.last_col) begin
            h_above = sub_dbl(prev_c_eff, prev_cm1_reg);
        end else begin
            h_above = sub_pix(prev_rd, prev_cm1_reg);
        end
        if (s1_flags_reg.row_is_one) begin
            v_above = sub_dbl(s1_pix_reg, prev_c_eff);
        end else begin
            v_above = sub_pix(s1_pix_reg, cur_rd);
        end
        // Last row, one column behind.
        if (s1_flags_reg.col_is_one) begin
            h_behind = sub_dbl(s1_pix_reg, pix_d1_reg);
        end else begin
            h_behind = sub_pix(s1_pix_reg, pix_d2_reg);
        end
        v_behind = sub_dbl(pix_d1_reg, prev_cm1_reg);
        // Bottom right corner.
        h_corner = sub_dbl(s1_pix_reg, pix_d1_reg);
        v_corner = sub_dbl(s1_pix_reg, prev_c_eff);
    end

    always_comb begin
        pick    = '0;
        sel_h   = h_corner;
        sel_v   = v_corner;
        sel_row = s1_row_reg;
        sel_col = s1_col_reg;
        priority if (pend[RES_ABOVE]) begin
            pick[RES_ABOVE] = 1'b1;
            sel_h   = h_above;
            sel_v   = v_above;
            sel_row = s1_row_reg - ROW_W'(1);
        end else if (pend[RES_BEHIND]) begin
            pick[RES_BEHIND] = 1'b1;
            sel_h   = h_behind;
            sel_v   = v_behind;
            sel_col = s1_col_reg - COL_W'(1);
        end else begin
            pick[RES_CORNER] = pend[RES_CORNER];
        end
    end

    assign col_wide = {{COL_OUT_W{1'b0}}, sel_col};

    always_comb begin
        if (complete) begin
            done_next = '0;
        end else if (emit) begin
            done_next = done_reg | pick;
        end else begin
            done_next = done_reg;
        end
        if (load) begin
            s1_valid_next = 1'b1;
        end else if (complete) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (out_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            s1_valid_reg <= 1'b0;
            done_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            done_reg     <= done_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            s1_pix_reg   <= ld_pix;
            s1_row_reg   <= ld_row;
            s1_col_reg   <= ld_col;
            s1_flags_reg <= ld_flags;
        end
        if (complete) begin
            prev_cm1_reg <= prev_c_eff;
            prev_c_reg   <= prev_rd;
            pix_d2_reg   <= pix_d1_reg;
            pix_d1_reg   <= s1_pix_reg;
            if (s1_flags_reg.first_col) begin
                first_prev_reg <= s1_pix_reg;
            end
        end
        if (emit) begin
            m_horiz_reg <= sel_h;
            m_vert_reg  <= sel_v;
            m_row_reg   <= sel_row;
            m_col_reg   <= col_wide[COL_OUT_W-1:0];
            m_last_reg  <= only_one;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_horiz = m_horiz_reg;
    assign out_vert  = m_vert_reg;
    assign out_row   = m_row_reg;
    assign out_col   = m_col_reg;
    assign out_last  = m_last_reg;

endmodule

>>> sv/image_central_difference_gradient.sv
// Top level of the central difference image gradient: registers, raster counters, datapath.
//
//  Channel   Direction  Handshake                 Contents
//  s_        in         s_tvalid / s_tready       tdata = pixel
//  m_        out        m_tvalid / m_tready       tdata = horiz, vert, row, col; tlast = last
//  APB       in/out     psel, penable, pready     frame_width @0x0, frame_height @0x4
//
// The first result of a pixel passes the held-pixel and output registers to m_tdata. A first-row
// pixel gives no result and a middle-row pixel gives one, so a pixel is taken every cycle there
// while m_tready holds. A last-row pixel gives two (one in the first column, three on the final
// pixel) and the single output register moves one per cycle, so the input waits on them there.
// Results for a row appear while the next row streams in. Reset is synchronous; the row
// memories need no clearing pass. Stalls on m_tready back up into s_tready without loss.
module image_central_difference_gradient #(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [icdg_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [icdg_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [icdg_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0: pixel.
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]       s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // Fields from bit 0: horiz_grad, vert_grad, out_row, out_col, zero fill.
    output logic [((2*PIXEL_BITS+4+icdg_pkg::ROW_W+icdg_pkg::COL_OUT_W+7)/8)*8-1:0] m_tdata,
    output logic                                  m_tlast
);
    import icdg_pkg::*;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int GRAD_W   = PIXEL_BITS + 2;
    localparam int OUT_BITS = 2 * GRAD_W + ROW_W + COL_OUT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int WCMP_W   = (COL_W + 1 > WREG_W) ? COL_W + 1 : WREG_W;

    logic [WREG_W-1:0]        frame_width_reg;
    logic [HREG_W-1:0]        frame_height_reg;
    logic [ROW_W-1:0]         row_count_reg;
    logic [ROW_W-1:0]         row_count_next;
    logic [COL_W-1:0]         col_count_reg;
    logic [COL_W-1:0]         col_count_next;
    logic                     sel_reg;
    logic                     sel_next;

    logic                     cfg_wr;
    icdg_reg_t                cfg_idx;
    logic                     accept;
    logic [WCMP_W-1:0]        width_raw;
    logic [WCMP_W-1:0]        width_eff;
    logic [HREG_W-1:0]        height_eff;
    logic                     last_col;
    logic                     last_row;
    logic [COL_W-1:0]         col_p1;
    icdg_flags_t              flags;
    logic [PIXEL_BITS-1:0]    pix;
    logic [PIXEL_BITS-1:0]    cur_rd;
    logic [PIXEL_BITS-1:0]    prev_rd;

    logic signed [GRAD_W-1:0] out_horiz;
    logic signed [GRAD_W-1:0] out_vert;
    logic [ROW_W-1:0]         out_row;
    logic [COL_OUT_W-1:0]     out_col;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_idx = icdg_reg_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            if (cfg_idx == REG_FRAME_WIDTH) begin
                frame_width_reg <= pwdata[WREG_W-1:0];
            end else begin
                frame_height_reg <= pwdata[HREG_W-1:0];
            end
        end
    end

    // Active frame size, clamped to the supported range.
    assign width_raw = WCMP_W'(frame_width_reg);

    always_comb begin
        if (width_raw < WCMP_W'(2)) begin
            width_eff = WCMP_W'(2);
        end else if (width_raw > WCMP_W'(MAX_WIDTH)) begin
            width_eff = WCMP_W'(MAX_WIDTH);
        end else begin
            width_eff = width_raw;
        end
        if (frame_height_reg < HREG_W'(2)) begin
            height_eff = HREG_W'(2);
        end else if (frame_height_reg > HREG_W'(MAX_HEIGHT)) begin
            height_eff = HREG_W'(MAX_HEIGHT);
        end else begin
            height_eff = frame_height_reg;
        end
    end

    // Raster position of the next pixel
    assign accept   = s_tvalid && s_tready;
    assign pix      = s_tdata[PIXEL_BITS-1:0];
    assign col_p1   = col_count_reg + COL_W'(1);
    assign last_col = (WCMP_W'(col_count_reg) + WCMP_W'(1)) == width_eff;
    assign last_row = (HREG_W'(row_count_reg) + HREG_W'(1)) == height_eff;

    assign flags.has_above  = row_count_reg != '0;
    assign flags.row_is_one = row_count_reg == ROW_W'(1);
    assign flags.last_row   = last_row;
    assign flags.last_col   = last_col;
    assign flags.first_col  = col_count_reg == '0;
    assign flags.col_is_one = col_count_reg == COL_W'(1);

    always_comb begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        sel_next       = sel_reg;
        if (cfg_wr) begin
            // Any register write restarts the frame.
            row_count_next = '0;
            col_count_next = '0;
            sel_next       = 1'b0;
        end else if (accept) begin
            if (last_col) begin
                col_count_next = '0;
                sel_next       = !sel_reg;
                row_count_next = last_row ? '0 : row_count_reg + ROW_W'(1);
            end else begin
                col_count_next = col_p1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            sel_reg       <= 1'b0;
        end else begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            sel_reg       <= sel_next;
        end
    end

    icdg_row_buf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_row_buf (
        .clk     (aclk),
        .wr_en   (accept),
        .sel     (sel_reg),
        .col     (col_count_reg),
        .col_p1  (col_p1),
        .pix     (pix),
        .cur_rd  (cur_rd),
        .prev_rd (prev_rd)
    );

    icdg_grad #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_grad (
        .clk       (aclk),
        .rstn      (aresetn),
        .load      (accept),
        .ld_pix    (pix),
        .ld_row    (row_count_reg),
        .ld_col    (col_count_reg),
        .ld_flags  (flags),
        .cur_rd    (cur_rd),
        .prev_rd   (prev_rd),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_horiz (out_horiz),
        .out_vert  (out_vert),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_last  (m_tlast)
    );

    assign m_tdata = OUT_W'({out_col, out_row, out_vert, out_horiz});

endmodule

>>> sv/icdg_checker.sv
// Port-level checks for the gradient block, bound to its top level.
module icdg_checker #(
    parameter int PIXEL_BITS = 16
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((2*PIXEL_BITS+4+icdg_pkg::ROW_W+icdg_pkg::COL_OUT_W+7)/8)*8-1:0] m_tdata,
    input logic                                  m_tlast
);
    import icdg_pkg::*;

    localparam int GRAD_W  = PIXEL_BITS + 2;
    localparam int VERT_LO = GRAD_W;
    localparam int ROW_LO  = 2 * GRAD_W;
    localparam int COL_LO  = 2 * GRAD_W + ROW_W;

    // A waiting result holds until its transfer.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Left border uses a doubled one-sided difference, so it is always even.
    a_left_even: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[COL_LO+COL_OUT_W-1:COL_LO] == '0) |-> !m_tdata[0])
        else $error("odd horizontal gradient in first column");

    // Top border likewise for the vertical gradient.
    a_top_even: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[ROW_LO+ROW_W-1:ROW_LO] == '0) |-> !m_tdata[VERT_LO])
        else $error("odd vertical gradient in first row");

endmodule

bind image_central_difference_gradient icdg_checker #(.PIXEL_BITS(PIXEL_BITS)) u_icdg_checker (.*);

>>> test/tb_top.sv
// Self-checking testbench for the central difference image gradient block.
`timescale 1ns / 100ps

module tb_top;
    import icdg_pkg::*;

    localparam int MAX_W       = 2048;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYC  = 8;

    typedef struct packed {
        logic [17:0] horiz;
        logic [17:0] vert;
        logic [11:0] row;
        logic [10:0] col;
        logic        last_of_run;
    } grad_res_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    // Fields from bit 0: pixel.
    logic [15:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // Fields from bit 0: horiz_grad, vert_grad, out_row, out_col, zero fill.
    logic [63:0]           m_tdata;
    logic                  m_tlast;

    image_central_difference_gradient u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Shadow copy of the block's frame state.
    logic [15:0]       line_mem [2][MAX_W];
    bit                line_sel;
    int                row_pos;
    int                col_pos;
    logic [WREG_W-1:0] cfg_width;
    logic [HREG_W-1:0] cfg_height;

    grad_res_t grad_q [$];
    grad_res_t want;
    grad_res_t got;
    int        mismatch_count;
    int        stall_cycles;
    int        send_idle_pct;
    int        recv_idle_pct;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int active_width();
        if (cfg_width < 2) return 2;
        if (cfg_width > MAX_W) return MAX_W;
        return int'(cfg_width);
    endfunction

    function automatic int active_height();
        if (cfg_height < 2) return 2;
        if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
        return int'(cfg_height);
    endfunction

    function automatic int cur_px(input int idx);
        return int'(line_mem[line_sel][idx]);
    endfunction

    function automatic int prev_px(input int idx);
        return int'(line_mem[line_sel ^ 1'b1][idx]);
    endfunction

    function automatic void push_grad(input int hz, input int vt, input int r, input int c,
                                      input bit is_last);
        grad_res_t g;
        g.horiz       = hz[17:0];
        g.vert        = vt[17:0];
        g.row         = r[11:0];
        g.col         = c[10:0];
        g.last_of_run = is_last;
        grad_q.push_back(g);
    endfunction

    // Works out every gradient result that one accepted pixel releases.
    function automatic void predict_gradients(input logic [15:0] pix);
        int w, hgt, r, c, p, hz, vt, k;
        bit last_row, last_col, has_behind, has_corner;
        w          = active_width();
        hgt        = active_height();
        r          = row_pos;
        c          = col_pos;
        p          = int'(pix);
        last_row   = (r + 1 == hgt);
        last_col   = (c + 1 == w);
        has_behind = last_row && (c >= 1);
        has_corner = last_row && last_col;

        // Result for the pixel directly above.
        if (r >= 1) begin
            if (c == 0)
                hz = 2 * (prev_px(1) - prev_px(0));
            else if (last_col)
                hz = 2 * (prev_px(c) - prev_px(c - 1));
            else
                hz = prev_px(c + 1) - prev_px(c - 1);
            vt = (r == 1) ? 2 * (p - prev_px(c)) : p - cur_px(c);
            push_grad(hz, vt, r - 1, c, !(has_behind || has_corner));
        end
        // On the bottom row the result for the left neighbor follows one pixel behind.
        if (has_behind) begin
            k  = c - 1;
            hz = (k == 0) ? 2 * (p - cur_px(0)) : p - cur_px(k - 1);
            vt = 2 * (cur_px(k) - prev_px(k));
            push_grad(hz, vt, r, k, !has_corner);
        end
        if (has_corner)
            push_grad(2 * (p - cur_px(c - 1)), 2 * (p - prev_px(c)), r, c, 1'b1);

        line_mem[line_sel][c] = pix;
        if (last_col) begin
            col_pos  = 0;
            line_sel = ~line_sel;
            row_pos  = last_row ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    function automatic logic [15:0] random_pixel();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic send_pixel(input logic [15:0] pix);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        predict_gradients(pix);
    endtask

    // Stops the input and lets every outstanding result drain out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (grad_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // psel is left high so that a second write can follow without a lowered cycle.
    task automatic write_reg(input icdg_reg_t idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_FRAME_WIDTH)
            cfg_width = value[WREG_W-1:0];
        else
            cfg_height = value[HREG_W-1:0];
        row_pos  = 0;
        col_pos  = 0;
        line_sel = 1'b0;
    endtask

    task automatic set_frame(input int unsigned width_val, input int unsigned height_val);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, width_val);
        write_reg(REG_FRAME_HEIGHT, height_val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Register values below the minimum act as a 2 by 2 frame; two frames check the wrap.
    task automatic test_smallest_frame();
        set_frame(0, 1);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
    endtask

    // A 3 by 3 frame has one interior pixel and every kind of border.
    task automatic test_borders();
        logic [15:0] pix [9];
        pix = '{16'h0000, 16'h0064, 16'hFFFF, 16'h0007, 16'hFFFF,
                16'h0000, 16'hFFFF, 16'h04D2, 16'h0000};
        set_frame(3, 3);
        foreach (pix[i]) send_pixel(pix[i]);
    endtask

    // A register write in the middle of a frame starts a new frame.
    task automatic test_restart();
        set_frame(3, 4);
        repeat (4) send_pixel(random_pixel());
        set_frame(2, 2);
        repeat (4) send_pixel(random_pixel());
    endtask

    // Register values above the maximum clamp; the first pixels of the widest frame are sent.
    task automatic test_clamp_high();
        set_frame(12'hFFF, 13'h1FFF);
        repeat (40) send_pixel(random_pixel());
    endtask

    task automatic test_random_frames(input int snd_pct, input int rcv_pct, input int n_items);
        int sent, wv, hv, total;
        sent = 0;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        while (sent < n_items) begin
            wv = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 2);
            hv = $urandom_range(6, 2);
            if ($urandom_range(11) == 0) wv = $urandom_range(1, 0);
            if ($urandom_range(11) == 0) hv = $urandom_range(1, 0);
            set_frame(wv, hv);
            total = $urandom_range(2, 1) * active_width() * active_height();
            // Now and then a frame is cut short by the next register write.
            if ($urandom_range(4) == 0) total = $urandom_range(total - 1, 1);
            if (total > n_items - sent) total = n_items - sent;
            repeat (total) send_pixel(random_pixel());
            sent += total;
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.horiz       = m_tdata[17:0];
            got.vert        = m_tdata[35:18];
            got.row         = m_tdata[47:36];
            got.col         = m_tdata[58:48];
            got.last_of_run = m_tlast;
            if (grad_q.size() == 0) begin
                if (mismatch_count < 10)
                    $display("Unexpected result: horiz %0d vert %0d row %0d col %0d last %0b",
                             $signed(got.horiz), $signed(got.vert), got.row, got.col,
                             got.last_of_run);
                mismatch_count++;
            end else begin
                want = grad_q.pop_front();
                if (got.horiz != want.horiz || got.vert != want.vert || got.row != want.row ||
                    got.col != want.col || got.last_of_run != want.last_of_run) begin
                    if (mismatch_count < 10)
                        $display({"Mismatch: expected horiz %0d vert %0d row %0d col %0d ",
                                  "last %0b, got horiz %0d vert %0d row %0d col %0d last %0b"},
                                 $signed(want.horiz), $signed(want.vert), want.row, want.col,
                                 want.last_of_run, $signed(got.horiz), $signed(got.vert),
                                 got.row, got.col, got.last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    // Any transfer on either stream or the register port resets the stall count.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        aresetn        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        m_tready       <= 1'b0;
        stall_cycles   <= 0;
        mismatch_count = 0;
        send_idle_pct  = 25;
        recv_idle_pct  = 74;
        cfg_width      = WIDTH_RESET;
        cfg_height     = HEIGHT_RESET;
        line_sel       = 1'b0;
        row_pos        = 0;
        col_pos        = 0;
        foreach (line_mem[i, j]) line_mem[i][j] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_smallest_frame();
        test_borders();
        test_restart();
        test_clamp_high();
        test_random_frames(25, 74, 115);
        test_random_frames(74, 25, 115);
        test_random_frames(0, 0, 115);

        wait_drained();
        if (grad_q.size() != 0) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
